// ----- hw/rtl/slipd_pkg.sv -----
// Package for the SLIP frame decoder: SLIP code bytes and the control state type.
// It has no dependencies. The frame memory and the decoder core both import it.
package slipd_pkg;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TYPE_RD,
    ST_TYPE_CHK,
    ST_DRAIN_RD,
    ST_DRAIN_LD,
    ST_DRAIN_WAIT
  } ctrl_state_t;

endpackage

// ----- hw/rtl/slipd_frame_mem.sv -----
// Frame store of the SLIP decoder. It has one write port and one synchronous read port.
// The read data is registered and appears in the cycle after the address. It depends on slipd_pkg.
module slipd_frame_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  slipd_pkg::byte_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output slipd_pkg::byte_t rd_data
);
  import slipd_pkg::*;

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hw/rtl/slip_frame_decoder_core.sv -----
// SLIP frame decoder core: input byte decode, frame store control and payload drain.
// It depends on slipd_pkg and on slipd_frame_mem.
// Throughput: one input word is taken per cycle while the control is idle; no input is taken
// during the type check or the drain. An END that closes a frame starts the type check, and
// each payload word then goes through: read the memory, load the output register, hand off.
// Reset (synchronous, rst_n low) clears the sync, escape, fill, counters and frame type.
// The frame memory itself is not cleared.
module slip_frame_decoder_core #(
  parameter int FRAME_BYTES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  slipd_pkg::byte_t in_rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output slipd_pkg::byte_t out_payload_byte,
  output logic             out_last_of_frame,
  output logic [15:0]      out_frames_seen,
  output logic [15:0]      out_escape_errors,
  input  logic             cfg_we,
  input  slipd_pkg::byte_t cfg_frame_type
);
  import slipd_pkg::*;

  localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(FRAME_BYTES);

  ctrl_state_t   state_r, state_nxt;
  logic          sync_r, sync_nxt;
  logic          esc_r, esc_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [15:0]   frame_cnt_r, frame_cnt_nxt;
  logic [15:0]   err_cnt_r, err_cnt_nxt;
  byte_t         type_r;
  logic          out_valid_r, out_valid_nxt;
  byte_t         out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;

  logic          wr_en;
  byte_t         wr_data;
  logic [AW-1:0] rd_addr;
  byte_t         rd_data;
  logic          in_acc;
  logic          store_req;
  byte_t         dec_byte;

  slipd_frame_mem #(
    .DEPTH(FRAME_BYTES),
    .AW   (AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(fill_r[AW-1:0]),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Reads are used only in the type check and drain states and writes happen only in idle. The state machine
  // keeps the two apart, so no forwarding path is needed.
  always_comb begin
    state_nxt     = state_r;
    sync_nxt      = sync_r;
    esc_nxt       = esc_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    frame_cnt_nxt = frame_cnt_r;
    err_cnt_nxt   = err_cnt_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    store_req     = 1'b0;
    dec_byte      = in_rx_byte;
    rd_addr       = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (!sync_r) begin
            if (in_rx_byte == SLIP_END) begin
              sync_nxt = 1'b1;
              fill_nxt = '0;
              esc_nxt  = 1'b0;
            end
          end else if (esc_r) begin
            priority if (in_rx_byte == SLIP_ESC_END) begin
              dec_byte = SLIP_END;
            end else if (in_rx_byte == SLIP_ESC_ESC) begin
              dec_byte = SLIP_ESC;
            end else begin
              if (err_cnt_r != 16'hFFFF) begin
                err_cnt_nxt = err_cnt_r + 16'd1;
              end
            end
            store_req = 1'b1;
            esc_nxt   = 1'b0;
          end else if (in_rx_byte == SLIP_ESC) begin
            esc_nxt = 1'b1;
          end else if (in_rx_byte != SLIP_END) begin
            store_req = 1'b1;
          end else begin
            if (fill_r != '0) begin
              if (frame_cnt_r != 16'hFFFF) begin
                frame_cnt_nxt = frame_cnt_r + 16'd1;
              end
              state_nxt = ST_TYPE_RD;
            end
          end
          if (store_req && (fill_r != FILL_FULL)) begin
            fill_nxt = fill_r + FW'(1);
          end
        end
      end
      ST_TYPE_RD: begin
        rd_addr   = '0;
        state_nxt = ST_TYPE_CHK;
      end
      ST_TYPE_CHK: begin
        if ((rd_data == type_r) && (fill_r > FW'(1))) begin
          idx_nxt   = AW'(1);
          state_nxt = ST_DRAIN_RD;
        end else begin
          fill_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN_RD: begin
        state_nxt = ST_DRAIN_LD;
      end
      ST_DRAIN_LD: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = rd_data;
        out_last_nxt  = ((FW'(idx_r) + FW'(1)) == fill_r);
        state_nxt     = ST_DRAIN_WAIT;
      end
      ST_DRAIN_WAIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            fill_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = ST_DRAIN_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign wr_en   = store_req && (fill_r != FILL_FULL);
  assign wr_data = dec_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sync_r      <= 1'b0;
      esc_r       <= 1'b0;
      fill_r      <= '0;
      frame_cnt_r <= '0;
      err_cnt_r   <= '0;
      type_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sync_r      <= sync_nxt;
      esc_r       <= esc_nxt;
      fill_r      <= fill_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      err_cnt_r   <= err_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        type_r <= cfg_frame_type;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = out_byte_r;
  assign out_last_of_frame = out_last_r;
  assign out_frames_seen   = frame_cnt_r;
  assign out_escape_errors = err_cnt_r;

endmodule

// ----- test/slip_frame_decoder_core_tb.sv -----
// Self-checking testbench for slip_frame_decoder_core: SLIP byte decode, frame store and payload
// drain, checked word by word against a predictor kept in this file.
// Depends on slipd_pkg and the RTL of slip_frame_decoder_core, and through it on slipd_frame_mem.
module slip_frame_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slipd_pkg::*;

  localparam int FRAME_BYTES        = 64;
  localparam int MAX_SHOWN          = 20;
  localparam int SETTLE_CYCLES      = 24;
  localparam int RESULT_WAIT_CYCLES = 20000;
  localparam int HOLD_CYCLES        = 400;

  typedef struct packed {
    byte_t       data;
    logic        last;
    logic [15:0] frames;
    logic [15:0] errors;
  } payload_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  byte_t       in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  byte_t       out_payload_byte;
  logic        out_last_of_frame;
  logic [15:0] out_frames_seen;
  logic [15:0] out_escape_errors;
  logic        cfg_we = 1'b0;
  byte_t       cfg_frame_type = 8'h00;

  slip_frame_decoder_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_frames_seen   (out_frames_seen),
    .out_escape_errors (out_escape_errors),
    .cfg_we            (cfg_we),
    .cfg_frame_type    (cfg_frame_type)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus and expectations.
  byte_t         link_bytes[$];
  payload_word_t payload_due[$];
  int            queued = 0;
  int            bytes_in = 0;
  int            words_out = 0;
  int            cfg_writes = 0;
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic          hold_request = 1'b0;
  logic          holding = 1'b0;

  // Predictor state.
  logic        synced = 1'b0;
  logic        escaped = 1'b0;
  byte_t       frame_mem[FRAME_BYTES];
  int unsigned fill = 0;
  logic [15:0] frame_cnt = 16'd0;
  logic [15:0] esc_err_cnt = 16'd0;
  byte_t       type_sel = 8'h00;

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  function automatic logic [15:0] bump16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  task keep_byte(input byte_t d);
    if (fill < FRAME_BYTES) begin
      frame_mem[fill] = d;
      fill++;
    end
  endtask

  // Advances the decoder state by one link word and queues the payload words it releases.
  task decode_rx_byte(input byte_t b);
    byte_t         d;
    payload_word_t w;
    if (!synced) begin
      if (b == SLIP_END) begin
        synced = 1'b1;
        fill = 0;
        escaped = 1'b0;
      end
    end else if (escaped) begin
      if (b == SLIP_ESC_END) begin
        d = SLIP_END;
      end else if (b == SLIP_ESC_ESC) begin
        d = SLIP_ESC;
      end else begin
        d = b;
        esc_err_cnt = bump16(esc_err_cnt);
      end
      keep_byte(d);
      escaped = 1'b0;
    end else if (b == SLIP_ESC) begin
      escaped = 1'b1;
    end else if (b != SLIP_END) begin
      keep_byte(b);
    end else if (fill != 0) begin
      frame_cnt = bump16(frame_cnt);
      if (frame_mem[0] == type_sel && fill > 1) begin
        for (int i = 1; i < fill; i++) begin
          w.data   = frame_mem[i];
          w.last   = (i == fill - 1);
          w.frames = frame_cnt;
          w.errors = esc_err_cnt;
          payload_due.push_back(w);
        end
      end
      fill = 0;
    end
  endtask

  // Sender: offers queued link words, idling at random between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_rx_byte(in_rx_byte);
        bytes_in++;
      end
      if (!in_valid || in_ready) begin
        if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_rx_byte <= link_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted payload word against the oldest expectation.
  always @(posedge clk) begin : payload_monitor
    payload_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        words_out++;
        if (payload_due.size() == 0) begin
          note_mismatch($sformatf("unexpected payload word %02h", out_payload_byte));
        end else begin
          want = payload_due.pop_front();
          if (out_payload_byte !== want.data) begin
            note_mismatch($sformatf("payload_byte %02h, want %02h", out_payload_byte, want.data));
          end
          if (out_last_of_frame !== want.last) begin
            note_mismatch($sformatf("last_of_frame %b, want %b", out_last_of_frame, want.last));
          end
          if (out_frames_seen !== want.frames) begin
            note_mismatch($sformatf("frames_seen %0d, want %0d", out_frames_seen, want.frames));
          end
          if (out_escape_errors !== want.errors) begin
            note_mismatch($sformatf("escape_errors %0d, want %0d",
                                    out_escape_errors, want.errors));
          end
        end
      end
      out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the store fills and the input backs up.
  initial begin : long_hold
    wait (hold_request);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  task automatic queue_link_byte(input byte_t b);
    link_bytes.push_back(b);
    queued++;
  endtask

  task automatic put_data(input byte_t b);
    if (b == SLIP_END) begin
      queue_link_byte(SLIP_ESC);
      queue_link_byte(SLIP_ESC_END);
    end else if (b == SLIP_ESC) begin
      queue_link_byte(SLIP_ESC);
      queue_link_byte(SLIP_ESC_ESC);
    end else begin
      queue_link_byte(b);
    end
  endtask

  // Payload values lean toward the SLIP code bytes.
  function automatic byte_t pick_byte();
    case ($urandom_range(9))
      0: return SLIP_END;
      1: return SLIP_ESC;
      2: return $urandom_range(1) ? SLIP_ESC_END : SLIP_ESC_ESC;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // One framed packet: type byte, len decoded payload bytes (some as invalid escapes), END.
  task automatic put_frame(input byte_t kind, input int len);
    byte_t bad;
    put_data(kind);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        do begin
          bad = byte_t'($urandom_range(255));
        end while (bad == SLIP_ESC_END || bad == SLIP_ESC_ESC);
        queue_link_byte(SLIP_ESC);
        queue_link_byte(bad);
      end else begin
        put_data(pick_byte());
      end
    end
    queue_link_byte(SLIP_END);
  endtask

  task automatic add_random_traffic(input int n);
    int target;
    int choice;
    target = queued + n;
    while (queued < target) begin
      choice = $urandom_range(99);
      if (choice < 80) begin
        put_frame(($urandom_range(3) != 0) ? type_sel : byte_t'($urandom_range(255)),
                  ($urandom_range(9) != 0) ? $urandom_range(8) : $urandom_range(70, 9));
      end else if (choice < 92) begin
        // Raw noise, which may hold stray ESC or END codes.
        repeat ($urandom_range(4, 1)) queue_link_byte(byte_t'($urandom_range(255)));
      end else begin
        queue_link_byte(SLIP_END);
      end
    end
  endtask

  task automatic write_frame_type(input byte_t v);
    @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_frame_type <= v;
    type_sel = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    @(negedge clk);
  endtask

  // Waits for the sender to empty, then for every expected word, then for the block to settle.
  task automatic wait_idle();
    int n;
    n = 0;
    do @(negedge clk); while (link_bytes.size() != 0 || in_valid);
    while (payload_due.size() != 0 && n < RESULT_WAIT_CYCLES) begin
      @(negedge clk);
      n++;
    end
    if (payload_due.size() != 0) begin
      note_mismatch($sformatf("%0d payload words never came out", payload_due.size()));
      payload_due.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_frame_type(8'h00);

    // Bytes before sync are dropped, an ESC among them included.
    queue_link_byte(SLIP_ESC);
    queue_link_byte(SLIP_ESC_END);
    queue_link_byte(8'h00);
    queue_link_byte(8'hFF);
    queue_link_byte(8'h55);
    queue_link_byte(SLIP_END);
    // An END with an empty store does nothing.
    queue_link_byte(SLIP_END);
    // Matching frame with both valid escapes, an invalid escape and an escaped END code.
    queue_link_byte(8'h00);
    queue_link_byte(8'h00);
    queue_link_byte(8'hFF);
    queue_link_byte(SLIP_ESC);
    queue_link_byte(SLIP_ESC_END);
    queue_link_byte(SLIP_ESC);
    queue_link_byte(SLIP_ESC_ESC);
    queue_link_byte(SLIP_ESC);
    queue_link_byte(8'h41);
    queue_link_byte(SLIP_ESC);
    queue_link_byte(SLIP_END);
    queue_link_byte(SLIP_END);
    // Type byte only, then a frame of another type.
    queue_link_byte(8'h00);
    queue_link_byte(SLIP_END);
    queue_link_byte(8'h55);
    queue_link_byte(8'h01);
    queue_link_byte(SLIP_END);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_frame_type(8'hFF);
    add_random_traffic(15);
    wait_idle();

    send_idle_pct  = 84;
    recv_stall_pct = 0;
    write_frame_type(SLIP_END);
    add_random_traffic(15);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 84;
    write_frame_type(byte_t'($urandom_range(255)));
    add_random_traffic(15);
    wait_idle();

    send_idle_pct  = 20;
    recv_stall_pct = 20;
    write_frame_type(SLIP_ESC);
    add_random_traffic(15);
    wait_idle();

    // Back-pressure: an exactly full frame, then an overflowing one whose tail is dropped,
    // with a dropped invalid escape at the end, while the receiver holds off.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_frame_type(8'h00);
    hold_request = 1'b1;
    put_frame(8'h00, FRAME_BYTES - 1);
    put_frame(8'h00, 0);
    void'(link_bytes.pop_back());
    queued--;
    repeat (FRAME_BYTES + 6) queue_link_byte(byte_t'($urandom_range(191)));
    queue_link_byte(SLIP_ESC);
    queue_link_byte(8'h33);
    queue_link_byte(SLIP_END);
    add_random_traffic(10);
    wait_idle();

    $display("Covered: %0d link words in, %0d payload words checked, %0d frame_type writes,",
             bytes_in, words_out, cfg_writes);
    $display("sync, escapes, store overflow and long back-pressure; %0d mismatches.",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(40_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/slipd_pkg.sv
hw/rtl/slipd_frame_mem.sv
hw/rtl/slip_frame_decoder_core.sv
test/slip_frame_decoder_core_tb.sv
